@@ rtl/vsa_pkg.sv @@
// shared types, constants and microcode table of the voxel surface area unit
package vsa_pkg;

   // payload widths
   localparam int COORD_W = 5;
   localparam int AREA_W = 18;
   // neighbor coordinate width: room for +1 up to 32 and for -1 wrapping far outside
   localparam int NBR_W = COORD_W + 2;
   localparam int NCNT_W = 3;
   localparam int FACES_PER_VOXEL = 6;

   // sequencer
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] STEP_WAIT = 4'd0;
   localparam logic [PC_W-1:0] STEP_SELF = 4'd1;
   localparam logic [PC_W-1:0] STEP_XM = 4'd2;
   localparam logic [PC_W-1:0] STEP_XP = 4'd3;
   localparam logic [PC_W-1:0] STEP_YM = 4'd4;
   localparam logic [PC_W-1:0] STEP_YP = 4'd5;
   localparam logic [PC_W-1:0] STEP_ZM = 4'd6;
   localparam logic [PC_W-1:0] STEP_ZP = 4'd7;
   localparam logic [PC_W-1:0] STEP_RESP = 4'd8;

   // memory address select
   localparam logic [2:0] ASEL_SELF = 3'd0;
   localparam logic [2:0] ASEL_XM = 3'd1;
   localparam logic [2:0] ASEL_XP = 3'd2;
   localparam logic [2:0] ASEL_YM = 3'd3;
   localparam logic [2:0] ASEL_YP = 3'd4;
   localparam logic [2:0] ASEL_ZM = 3'd5;
   localparam logic [2:0] ASEL_ZP = 3'd6;

   // jump conditions
   localparam logic [2:0] COND_NONE = 3'd0;
   localparam logic [2:0] COND_NO_INPUT = 3'd1;
   localparam logic [2:0] COND_OUT_GRID = 3'd2;
   localparam logic [2:0] COND_PRESENT = 3'd3;
   localparam logic [2:0] COND_RSP_BUSY = 3'd4;

   typedef struct packed {
      logic            take;      // accept a transaction in this step
      logic            rd_en;     // read occupancy at asel
      logic [2:0]      asel;
      logic            cap_self;  // data arriving is the voxel itself
      logic            acc_nbr;   // data arriving is a neighbor
      logic            respond;   // write back, update count, load response
      logic            last;      // fall through to the first step
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } ctl_word_type;

   typedef struct packed {
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
   } req_payload_type;

   typedef struct packed {
      logic [AREA_W-1:0] surface_area;
      logic              already_present;
   } rsp_payload_type;

   // microcode rom
   function automatic ctl_word_type micro_rom(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      w = '0;
      unique case (pc)
         STEP_WAIT: begin
            w.take = 1'b1; w.cond = COND_NO_INPUT; w.target = STEP_WAIT;
         end
         STEP_SELF: begin
            w.rd_en = 1'b1; w.asel = ASEL_SELF;
            w.cond = COND_OUT_GRID; w.target = STEP_RESP;
         end
         STEP_XM: begin
            w.rd_en = 1'b1; w.asel = ASEL_XM; w.cap_self = 1'b1;
            w.cond = COND_PRESENT; w.target = STEP_RESP;
         end
         STEP_XP: begin
            w.rd_en = 1'b1; w.asel = ASEL_XP; w.acc_nbr = 1'b1;
         end
         STEP_YM: begin
            w.rd_en = 1'b1; w.asel = ASEL_YM; w.acc_nbr = 1'b1;
         end
         STEP_YP: begin
            w.rd_en = 1'b1; w.asel = ASEL_YP; w.acc_nbr = 1'b1;
         end
         STEP_ZM: begin
            w.rd_en = 1'b1; w.asel = ASEL_ZM; w.acc_nbr = 1'b1;
         end
         STEP_ZP: begin
            w.rd_en = 1'b1; w.asel = ASEL_ZP; w.acc_nbr = 1'b1;
         end
         STEP_RESP: begin
            w.acc_nbr = 1'b1; w.respond = 1'b1; w.last = 1'b1;
            w.cond = COND_RSP_BUSY; w.target = STEP_RESP;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/vsa_channels.sv @@
// valid/ready channel interfaces for voxel requests and area responses
interface vsa_req_if;
   import vsa_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] coord_x;
   logic [COORD_W-1:0] coord_y;
   logic [COORD_W-1:0] coord_z;
   modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
   modport sink (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface vsa_rsp_if;
   import vsa_pkg::*;
   logic              valid;
   logic              ready;
   logic [AREA_W-1:0] surface_area;
   logic              already_present;
   modport source (output valid, output surface_area, output already_present, input ready);
   modport sink (input valid, input surface_area, input already_present, output ready);
endinterface

@@ rtl/voxel_surface_area_unit.sv @@
// voxel surface area unit: occupancy bitmap, microcoded sequencer, running face count
//
// Usage: each request transaction on req_chan carries one voxel (coord_x, coord_y,
// coord_z). The unit answers with exactly one response transaction on rsp_chan
// holding the exposed face count of all voxels inserted so far and a flag that
// is set when the voxel was already occupied (count then unchanged). Coordinates
// outside the grid leave everything unchanged and answer with the current count.
// Steps: a new voxel reaches the response register after a self read, six
// neighbor reads and a write-back step; a repeated voxel goes to the write-back
// step after the self read and the first neighbor read, an out-of-grid voxel
// right after the self read. No new request is taken until that step is left.
// The sequence is set by the single-port occupancy memory, one access per cycle,
// stepped by the microcode table.
// Reset: the count goes to zero and a clearing pass writes every occupancy bit,
// one per cycle, (2^clog2(GRID_SIDE))^3 bits in all (32768 at the default);
// req_chan.ready stays low meanwhile.
// Stall: the response sits in an output register; while it waits the unit takes
// and works the next request and holds in its write-back step until the
// register is free.
module voxel_surface_area_unit #(
   parameter int GRID_SIDE = 32
) (
   input  logic clock,
   input  logic reset,
   vsa_req_if.sink   req_chan,
   vsa_rsp_if.source rsp_chan
);
   import vsa_pkg::*;

   localparam int CW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
   localparam int AW = 3 * CW;
   localparam int DEPTH = 1 << AW;
   localparam logic [NBR_W-1:0] SIDE = NBR_W'(GRID_SIDE);

   // sequencer and datapath registers
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   logic               present_ff, present_in;
   logic [NCNT_W-1:0]  nbr_ff, nbr_in;
   logic [AREA_W-1:0]  count_ff, count_in;
   logic               rd_data_ff;
   logic               rd_ok_ff;
   logic               clr_active_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   logic mem [DEPTH];

   ctl_word_type       ctl;
   logic               accept;
   logic               rsp_busy;
   logic               go;
   logic               jump;
   logic               self_full;
   logic               in_grid;
   logic               update_en;
   logic [NCNT_W-1:0]  nbr_sum;
   logic [AREA_W-1:0]  area_new;
   logic [NBR_W-1:0]   ax, ay, az;
   logic               addr_ok;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      self_addr;

   assign ctl = micro_rom(pc_ff);

   // handshakes
   assign req_chan.ready = ctl.take && !clr_active_ff;
   assign accept = req_chan.valid && req_chan.ready;
   assign rsp_busy = rsp_valid_ff && !rsp_chan.ready;
   assign go = ctl.respond && !rsp_busy;

   // neighbor address generation and grid check
   always_comb begin
      ax = NBR_W'(cx_ff);
      ay = NBR_W'(cy_ff);
      az = NBR_W'(cz_ff);
      unique case (ctl.asel)
         ASEL_XM: ax = ax - NBR_W'(1);
         ASEL_XP: ax = ax + NBR_W'(1);
         ASEL_YM: ay = ay - NBR_W'(1);
         ASEL_YP: ay = ay + NBR_W'(1);
         ASEL_ZM: az = az - NBR_W'(1);
         ASEL_ZP: az = az + NBR_W'(1);
         default: ;
      endcase
   end

   assign addr_ok = (ax < SIDE) && (ay < SIDE) && (az < SIDE);
   assign rd_addr = {ax[CW-1:0], ay[CW-1:0], az[CW-1:0]};
   assign in_grid = (NBR_W'(cx_ff) < SIDE) && (NBR_W'(cy_ff) < SIDE)
                    && (NBR_W'(cz_ff) < SIDE);
   assign self_addr = {CW'(cx_ff), CW'(cy_ff), CW'(cz_ff)};

   // arriving occupancy data
   assign self_full = rd_data_ff && rd_ok_ff;
   assign nbr_sum = nbr_ff + NCNT_W'(self_full);
   assign area_new = count_ff + AREA_W'(FACES_PER_VOXEL) - AREA_W'({nbr_sum, 1'b0});
   assign update_en = in_grid && !present_ff;

   // jump condition
   always_comb begin
      unique case (ctl.cond)
         COND_NO_INPUT: jump = !accept;
         COND_OUT_GRID: jump = !in_grid;
         COND_PRESENT:  jump = self_full;
         COND_RSP_BUSY: jump = rsp_busy;
         default:       jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      priority if (jump) begin
         pc_in = ctl.target;
      end else if (ctl.last) begin
         pc_in = STEP_WAIT;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   // per-item state
   always_comb begin
      present_in = present_ff;
      nbr_in = nbr_ff;
      count_in = count_ff;
      if (accept) begin
         present_in = 1'b0;
         nbr_in = '0;
      end
      if (ctl.cap_self) begin
         present_in = self_full;
      end
      if (ctl.acc_nbr) begin
         nbr_in = nbr_sum;
      end
      if (go && update_en) begin
         count_in = area_new;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_addr_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         count_ff <= count_in;
         rd_ok_ff <= ctl.rd_en && addr_ok;
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               clr_active_ff <= 1'b0;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      present_ff <= present_in;
      nbr_ff <= nbr_in;
      if (accept) begin
         cx_ff <= req_chan.coord_x;
         cy_ff <= req_chan.coord_y;
         cz_ff <= req_chan.coord_z;
      end
      if (go) begin
         rsp_data_ff.surface_area <= count_in;
         rsp_data_ff.already_present <= present_ff && in_grid;
      end
   end

   // occupancy memory, single port
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (go && update_en) begin
         mem[self_addr] <= 1'b1;
      end else if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.surface_area = rsp_data_ff.surface_area;
   assign rsp_chan.already_present = rsp_data_ff.already_present;

endmodule

@@ rtl/vsa_checker.sv @@
// port-level checker of the voxel surface area unit and its bind
module vsa_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [vsa_pkg::AREA_W-1:0] surface_area,
   input logic                      already_present
);
   import vsa_pkg::*;

   logic [AREA_W-1:0] last_area_ff;
   logic              rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   // count last delivered to the receiver
   always_ff @(posedge clock) begin
      if (reset) begin
         last_area_ff <= '0;
      end else if (rsp_take) begin
         last_area_ff <= surface_area;
      end
   end

   // clearing pass holds off requests right after reset
   a_clear_blocks: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !req_ready)
      else $error("request accepted during clearing pass");

   // a waiting response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(surface_area)))
      else $error("response dropped or changed while stalled");

   // repeated voxel leaves the count unchanged
   a_repeat_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && already_present) |-> (surface_area == last_area_ff))
      else $error("count changed on a repeated voxel");

   // one voxel adds at most six faces, and every step is even
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> ((!surface_area[0])
         && ({1'b0, surface_area} <= {1'b0, last_area_ff} + (AREA_W + 1)'(FACES_PER_VOXEL))))
      else $error("count step out of range");

endmodule

bind voxel_surface_area_unit vsa_checker u_vsa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .surface_area    (rsp_chan.surface_area),
   .already_present (rsp_chan.already_present)
);

@@ bench/tb_top.sv @@
// testbench for the voxel surface area unit: running face count predictor and checker
`timescale 1ns / 1ps

module tb_top;
   import vsa_pkg::*;

   localparam int GRID_SIDE = 32;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int DRAIN_CYCLES = 20;

   // tracks the occupancy grid and face count, queues the expected responses
   class surface_tracker;
      bit                 occupied [GRID_CELLS];
      bit [AREA_W-1:0]    face_total;
      rsp_payload_type    expected_areas [$];
      int                 mismatches;

      // neighbors past the grid edge read as empty
      function bit cell_full(int x, int y, int z);
         if (x < 0 || y < 0 || z < 0 || x >= GRID_SIDE || y >= GRID_SIDE || z >= GRID_SIDE)
            return 1'b0;
         return occupied[(x * GRID_SIDE + y) * GRID_SIDE + z];
      endfunction

      // accepted voxel transaction: update the grid and queue the response it causes
      function void add_voxel(req_payload_type v);
         rsp_payload_type want;
         int x, y, z, nbrs;
         x = int'(v.coord_x);
         y = int'(v.coord_y);
         z = int'(v.coord_z);
         want = '0;
         if (x < GRID_SIDE && y < GRID_SIDE && z < GRID_SIDE) begin
            if (cell_full(x, y, z)) begin
               want.already_present = 1'b1;
            end else begin
               nbrs = cell_full(x - 1, y, z) + cell_full(x + 1, y, z)
                    + cell_full(x, y - 1, z) + cell_full(x, y + 1, z)
                    + cell_full(x, y, z - 1) + cell_full(x, y, z + 1);
               face_total = AREA_W'(int'(face_total) + FACES_PER_VOXEL - 2 * nbrs);
               occupied[(x * GRID_SIDE + y) * GRID_SIDE + z] = 1'b1;
            end
         end
         want.surface_area = face_total;
         expected_areas.push_back(want);
      endfunction

      // accepted response transaction: compare with the oldest expectation
      function void check_area(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_areas.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: area %0d present %0b",
                        got.surface_area, got.already_present);
            return;
         end
         want = expected_areas.pop_front();
         if (got.surface_area !== want.surface_area ||
             got.already_present !== want.already_present) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected area %0d present %0b, got area %0d present %0b",
                        want.surface_area, want.already_present,
                        got.surface_area, got.already_present);
         end
      endfunction

      function int waiting();
         return expected_areas.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   vsa_req_if req_bus ();
   vsa_rsp_if rsp_bus ();

   surface_tracker   tracker;
   req_payload_type  sent_voxels [$];
   int               send_idle_pct;
   int               rsp_stall_pct;

   voxel_surface_area_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_area('{surface_area: rsp_bus.surface_area,
                              already_present: rsp_bus.already_present});
   end

   function automatic req_payload_type vox(int x, int y, int z);
      return '{coord_x: COORD_W'(x), coord_y: COORD_W'(y), coord_z: COORD_W'(z)};
   endfunction

   // one voxel transaction, with a random idle gap ahead of it
   task automatic send_voxel(input req_payload_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.coord_x <= v.coord_x;
      req_bus.coord_y <= v.coord_y;
      req_bus.coord_z <= v.coord_z;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      tracker.add_voxel(v);
      sent_voxels.push_back(v);
   endtask

   // stimulus and end of run
   initial begin
      int base_x, base_y, base_z, pick;
      req_payload_type v;
      tracker = new();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      req_bus.coord_z = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // grid corners, a repeat, a 2x2x2 block, a voxel buried on all six sides
      send_voxel(vox(0, 0, 0));
      send_voxel(vox(0, 0, 0));
      send_voxel(vox(31, 31, 31));
      send_voxel(vox(31, 31, 30));
      send_voxel(vox(31, 0, 0));
      send_voxel(vox(0, 31, 0));
      send_voxel(vox(0, 0, 31));
      send_voxel(vox(1, 0, 0));
      send_voxel(vox(0, 1, 0));
      send_voxel(vox(1, 1, 0));
      send_voxel(vox(0, 0, 1));
      send_voxel(vox(1, 0, 1));
      send_voxel(vox(0, 1, 1));
      send_voxel(vox(1, 1, 1));
      send_voxel(vox(15, 16, 16));
      send_voxel(vox(17, 16, 16));
      send_voxel(vox(16, 15, 16));
      send_voxel(vox(16, 17, 16));
      send_voxel(vox(16, 16, 15));
      send_voxel(vox(16, 16, 17));
      send_voxel(vox(16, 16, 16));
      send_voxel(vox(16, 16, 16));

      // random phases: clustered shapes, repeats and scattered voxels
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 25 == 0) begin
               base_x = $urandom_range(28);
               base_y = $urandom_range(28);
               base_z = $urandom_range(28);
            end
            pick = $urandom_range(99);
            if (pick < 60)
               v = vox(base_x + $urandom_range(3), base_y + $urandom_range(3),
                       base_z + $urandom_range(3));
            else if (pick < 75)
               v = sent_voxels[$urandom_range(sent_voxels.size() - 1)];
            else
               v = vox($urandom_range(31), $urandom_range(31), $urandom_range(31));
            send_voxel(v);
         end
      end
      req_bus.valid <= 1'b0;

      // drain, then watch a little longer for stray responses
      while (tracker.waiting() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.waiting() == 0)
         $display("[voxel_surface_area_unit] OK");
      else
         $display("[voxel_surface_area_unit] ERROR");
      $finish;
   end

   // run deadline, covers the clearing pass after reset
   initial begin
      #4_000_000;
      $display("[voxel_surface_area_unit] ERROR");
      $finish;
   end

endmodule
